[hw/rtl/btgr_pkg.sv]
// Shared types, constants and register codes of the bitmap text glyph renderer.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package btgr_pkg;

    // Glyph memory geometry. The byte count is a power of two so that every
    // address wraps by truncation.
    localparam int FONT_BYTES      = 8192;
    localparam int FONT_AW         = $clog2(FONT_BYTES);
    localparam int MAX_GLYPH_BYTES = 48;
    localparam int CNT_W           = $clog2(MAX_GLYPH_BYTES + 1);
    localparam int QUEUE_DEPTH_DEF = 4;

    // The font table starts at the space character.
    localparam logic [7:0] FIRST_CODE = 8'h20;

    // Configuration port.
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    localparam logic [2:0] REG_GLYPH_WIDTH  = 3'd0;
    localparam logic [2:0] REG_GLYPH_HEIGHT = 3'd1;
    localparam logic [2:0] REG_TEXT_COLOR   = 3'd2;
    localparam logic [2:0] REG_BACK_COLOR   = 3'd3;
    localparam logic [2:0] REG_SCREEN_W     = 3'd4;
    localparam logic [2:0] REG_SCREEN_H     = 3'd5;
    localparam logic [2:0] REG_WIN_X        = 3'd6;
    localparam logic [2:0] REG_WIN_Y        = 3'd7;

    // Input commands and result kinds.
    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_DRAW    = 1'b1;
    localparam logic KIND_WINDOW = 1'b0;
    localparam logic KIND_PIXELS = 1'b1;

    typedef struct packed {
        logic [4:0]  glyph_width;
        logic [4:0]  glyph_height;
        logic [15:0] text_color;
        logic [15:0] back_color;
        logic [15:0] screen_w;
        logic [15:0] screen_h;
        logic [15:0] win_x;
        logic [15:0] win_y;
    } t_cfg;

    // One classified job handed from the front end to the back end. For a
    // load, addr and data are the byte to store; for a draw, addr is the
    // glyph base address and the rest describes the window.
    typedef struct packed {
        logic               draw;
        logic [FONT_AW-1:0] addr;
        logic [7:0]         data;
        logic [CNT_W-1:0]   count;
        logic [15:0]        x_first;
        logic [15:0]        x_last;
        logic [15:0]        y_first;
        logic [15:0]        y_last;
    } t_job;

endpackage

`default_nettype wire

[hw/rtl/btgr_ifs.sv]
// Handshake channels of the glyph renderer: the command item channel and the
// result item channel. Depends on btgr_pkg for the address width.
`default_nettype none

interface btgr_item_if import btgr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [FONT_AW-1:0] font_addr;
    logic [7:0]         font_byte;
    logic [7:0]         char_code;
    logic               new_string;
    logic [15:0]        start_line;

    modport source (
        output valid, cmd, font_addr, font_byte, char_code, new_string, start_line,
        input  ready
    );
    modport sink (
        input  valid, cmd, font_addr, font_byte, char_code, new_string, start_line,
        output ready
    );
endinterface

interface btgr_res_if ();
    logic        valid;
    logic        ready;
    logic        kind;
    logic [15:0] x_first;
    logic [15:0] x_last;
    logic [15:0] y_first;
    logic [15:0] y_last;
    logic [63:0] pixels_a;
    logic [63:0] pixels_b;
    logic        last;

    modport source (
        output valid, kind, x_first, x_last, y_first, y_last, pixels_a, pixels_b, last,
        input  ready
    );
    modport sink (
        input  valid, kind, x_first, x_last, y_first, y_last, pixels_a, pixels_b, last,
        output ready
    );
endinterface

`default_nettype wire

[hw/rtl/bitmap_text_glyph_renderer.sv]
// Top level of the bitmap text glyph renderer: configuration registers and
// the front end, job queue and back end. Depends on btgr_pkg, btgr_ifs and
// btgr_front, btgr_queue, btgr_back.
//
//  Channel   Direction  Handshake              Carries
//  i_item    in         valid/ready            cmd, font_addr, font_byte, char_code,
//                                              new_string, start_line
//  o_res     out        valid/ready            kind, window corners, 8 colors, last
//  APB       in/out     psel/penable/pready    eight configuration registers
//
// A load passes the front end through accept and job hand-off and is written
// when the back end pops it. A draw passes the front-end states accept,
// horizontal wrap, vertical wrap and job hand-off, then the back end gives the
// window item and one color item per glyph byte at one item per cycle while
// the output is not stalled, paced by the single read port of the glyph memory.
// Reset clears the cursor, the queue and all handshake state and loads the
// register defaults; the glyph memory is not cleared and must be loaded first.
// A stalled result waits in the output register while the queue lets the
// front end keep taking items until it holds QUEUE_DEPTH jobs.
`default_nettype none

module bitmap_text_glyph_renderer import btgr_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF  // at least 2
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    btgr_item_if.sink          i_item,
    btgr_res_if.source         o_res,
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire [PADDR_W-1:0]  paddr,
    input  wire [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    // Configuration registers, one 32-bit word each.
    t_cfg       r_cfg;
    logic [2:0] reg_idx;
    logic       cfg_wr;

    // Queue connections between the two halves.
    logic push, full, pop, empty;
    t_job push_job, pop_job;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.glyph_width  <= 5'd8;
            r_cfg.glyph_height <= 5'd16;
            r_cfg.text_color   <= '0;
            r_cfg.back_color   <= '0;
            r_cfg.screen_w     <= 16'd240;
            r_cfg.screen_h     <= 16'd320;
            r_cfg.win_x        <= '0;
            r_cfg.win_y        <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_GLYPH_WIDTH:  r_cfg.glyph_width  <= pwdata[4:0];
                REG_GLYPH_HEIGHT: r_cfg.glyph_height <= pwdata[4:0];
                REG_TEXT_COLOR:   r_cfg.text_color   <= pwdata[15:0];
                REG_BACK_COLOR:   r_cfg.back_color   <= pwdata[15:0];
                REG_SCREEN_W:     r_cfg.screen_w     <= pwdata[15:0];
                REG_SCREEN_H:     r_cfg.screen_h     <= pwdata[15:0];
                REG_WIN_X:        r_cfg.win_x        <= pwdata[15:0];
                REG_WIN_Y:        r_cfg.win_y        <= pwdata[15:0];
                default:          ;
            endcase
        end
    end

    // Register read-back, zero-extended to the bus width.
    always_comb begin
        unique case (reg_idx)
            REG_GLYPH_WIDTH:  prdata = PDATA_W'(r_cfg.glyph_width);
            REG_GLYPH_HEIGHT: prdata = PDATA_W'(r_cfg.glyph_height);
            REG_TEXT_COLOR:   prdata = PDATA_W'(r_cfg.text_color);
            REG_BACK_COLOR:   prdata = PDATA_W'(r_cfg.back_color);
            REG_SCREEN_W:     prdata = PDATA_W'(r_cfg.screen_w);
            REG_SCREEN_H:     prdata = PDATA_W'(r_cfg.screen_h);
            REG_WIN_X:        prdata = PDATA_W'(r_cfg.win_x);
            REG_WIN_Y:        prdata = PDATA_W'(r_cfg.win_y);
            default:          prdata = '0;
        endcase
    end

    // The front end owns the text cursor and classifies each item.
    btgr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_item  (i_item),
        .o_push  (push),
        .o_job   (push_job),
        .i_full  (full)
    );

    // Loads and draws share the queue, so font writes stay in order with the
    // glyph reads of earlier draws.
    btgr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_job   (pop_job),
        .o_empty (empty)
    );

    // The back end owns the glyph memory and the output register.
    btgr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_job   (pop_job),
        .i_empty (empty),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

[hw/rtl/btgr_front.sv]
// Front end of the glyph renderer: accepts command items, runs the text cursor
// and turns each item into a job for the queue. Depends on btgr_pkg, btgr_ifs.
`default_nettype none

module btgr_front import btgr_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  t_cfg        i_cfg,
    btgr_item_if.sink   i_item,
    output logic        o_push,
    output t_job        o_job,
    input  wire         i_full
);

    localparam logic [1:0] F_IDLE  = 2'd0;
    localparam logic [1:0] F_XWRAP = 2'd1;
    localparam logic [1:0] F_YWRAP = 2'd2;
    localparam logic [1:0] F_JOB   = 2'd3;

    logic [1:0]         r_state, n_state;
    logic               r_cmd;
    logic [FONT_AW-1:0] r_addr;
    logic [7:0]         r_byte;
    logic [7:0]         r_code;
    logic               r_new;
    logic [15:0]        r_start;
    logic [15:0]        r_cur_x, n_cur_x;
    logic [15:0]        r_cur_line, n_cur_line;
    logic [CNT_W-1:0]   r_fsize;
    logic [15:0]        r_offs;

    logic [15:0]        w16, h16;
    logic [15:0]        x0, l0, x_span, y_span;
    logic [9:0]         area;
    logic [6:0]         area_bytes;
    logic [CNT_W-1:0]   fsize;
    logic [CNT_W+15:0]  base_full;
    logic               accept;

    assign w16        = {11'd0, i_cfg.glyph_width};
    assign h16        = {11'd0, i_cfg.glyph_height};
    assign accept     = i_item.valid && i_item.ready;
    assign i_item.ready = (r_state == F_IDLE);

    // A new string restarts at column zero on its own start line.
    assign x0     = r_new ? 16'd0 : r_cur_x;
    assign l0     = r_new ? r_start : r_cur_line;
    assign x_span = x0 - i_cfg.win_x + w16;
    assign y_span = r_cur_line - i_cfg.win_y + h16;

    // Glyph byte count, floored and saturated.
    assign area       = {5'd0, i_cfg.glyph_width} * {5'd0, i_cfg.glyph_height};
    assign area_bytes = area[9:3];
    assign fsize      = (area_bytes > 7'(MAX_GLYPH_BYTES)) ? CNT_W'(MAX_GLYPH_BYTES)
                                                           : CNT_W'(area_bytes);

    assign base_full = r_offs * r_fsize;

    always_comb begin
        n_state    = r_state;
        n_cur_x    = r_cur_x;
        n_cur_line = r_cur_line;
        o_push     = 1'b0;
        o_job      = '0;
        unique case (r_state)
            F_IDLE: begin
                if (accept) begin
                    n_state = (i_item.cmd == CMD_DRAW) ? F_XWRAP : F_JOB;
                end
            end
            F_XWRAP: begin
                if (x_span > i_cfg.screen_w) begin
                    n_cur_x    = i_cfg.win_x;
                    n_cur_line = l0 + h16;
                end else begin
                    n_cur_x    = x0;
                    n_cur_line = l0;
                end
                n_state = F_YWRAP;
            end
            F_YWRAP: begin
                if (y_span > i_cfg.screen_h) begin
                    n_cur_x    = i_cfg.win_x;
                    n_cur_line = i_cfg.win_y;
                end
                n_state = F_JOB;
            end
            F_JOB: begin
                o_push = !i_full;
                if (r_cmd == CMD_DRAW) begin
                    o_job.draw    = 1'b1;
                    o_job.addr    = base_full[FONT_AW-1:0];
                    o_job.count   = r_fsize;
                    o_job.x_first = r_cur_x;
                    o_job.x_last  = r_cur_x + w16 - 16'd1;
                    o_job.y_first = r_cur_line;
                    o_job.y_last  = r_cur_line + h16 - 16'd1;
                end else begin
                    o_job.draw = 1'b0;
                    o_job.addr = r_addr;
                    o_job.data = r_byte;
                end
                if (!i_full) begin
                    if (r_cmd == CMD_DRAW) begin
                        n_cur_x = r_cur_x + w16;
                    end
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= F_IDLE;
            r_cur_x    <= '0;
            r_cur_line <= '0;
        end else begin
            r_state    <= n_state;
            r_cur_x    <= n_cur_x;
            r_cur_line <= n_cur_line;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd   <= i_item.cmd;
            r_addr  <= i_item.font_addr;
            r_byte  <= i_item.font_byte;
            r_code  <= i_item.char_code;
            r_new   <= i_item.new_string;
            r_start <= i_item.start_line;
        end
        if (r_state == F_XWRAP) begin
            r_fsize <= fsize;
            r_offs  <= {8'd0, r_code} - {8'd0, FIRST_CODE};
        end
    end

endmodule

`default_nettype wire

[hw/rtl/btgr_queue.sv]
// Short job queue between the front and back ends of the glyph renderer.
// Depends on btgr_pkg for the job type.
`default_nettype none

module btgr_queue import btgr_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_push,
    input  t_job  i_job,
    output logic  o_full,
    input  wire   i_pop,
    output t_job  o_job,
    output logic  o_empty
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_QW = $clog2(DEPTH + 1);

    t_job              r_mem [DEPTH];
    logic [IDX_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_QW-1:0] r_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == CNT_QW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == IDX_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == IDX_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/btgr_back.sv]
// Back end of the glyph renderer: holds the glyph memory, executes loads and
// streams the window and color items of each draw. Depends on btgr_pkg, btgr_ifs.
`default_nettype none

module btgr_back import btgr_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  t_cfg        i_cfg,
    input  t_job        i_job,
    input  wire         i_empty,
    output logic        o_pop,
    btgr_res_if.source  o_res
);

    localparam logic [1:0] B_IDLE  = 2'd0;
    localparam logic [1:0] B_WIN   = 2'd1;
    localparam logic [1:0] B_BYTES = 2'd2;

    logic [7:0]         mem [FONT_BYTES];
    logic [1:0]         r_state;
    t_job               r_job;
    logic [CNT_W-1:0]   r_issue, r_sent;
    logic               r_rd_valid;
    logic [7:0]         r_rd_data;

    logic               r_out_valid;
    logic               r_out_kind;
    logic [15:0]        r_out_xf, r_out_xl, r_out_yf, r_out_yl;
    logic [63:0]        r_out_pa, r_out_pb;
    logic               r_out_last;

    logic               out_free, mv, rd_en, win_go;
    logic [FONT_AW-1:0] rd_addr;

    function automatic logic [63:0] expand4(input logic [3:0] bits,
                                            input logic [15:0] fg,
                                            input logic [15:0] bg);
        logic [63:0] word;
        word = '0;
        for (int k = 0; k < 4; k++) begin
            word[63 - 16 * k -: 16] = bits[3 - k] ? fg : bg;
        end
        return word;
    endfunction

    assign out_free = !r_out_valid || o_res.ready;
    assign o_pop    = (r_state == B_IDLE) && !i_empty;
    assign win_go   = (r_state == B_WIN) && out_free;
    assign mv       = (r_state == B_BYTES) && r_rd_valid && out_free;
    assign rd_en    = (r_state == B_BYTES) && (r_issue < r_job.count) && (!r_rd_valid || mv);
    assign rd_addr  = r_job.addr + FONT_AW'(r_issue);

    always_ff @(posedge i_clk) begin
        if (o_pop && !i_job.draw) begin
            mem[i_job.addr] <= i_job.data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_issue     <= '0;
            r_sent      <= '0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (win_go || mv) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (rd_en) begin
                r_rd_valid <= 1'b1;
                r_issue    <= r_issue + 1'b1;
            end else if (mv) begin
                r_rd_valid <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (o_pop && i_job.draw) begin
                        r_state <= B_WIN;
                    end
                end
                B_WIN: begin
                    r_issue <= '0;
                    r_sent  <= '0;
                    if (win_go) begin
                        r_state <= (r_job.count == '0) ? B_IDLE : B_BYTES;
                    end
                end
                B_BYTES: begin
                    if (mv) begin
                        r_sent <= r_sent + 1'b1;
                        if (CNT_W'(r_sent + 1'b1) == r_job.count) begin
                            r_state <= B_IDLE;
                        end
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (win_go) begin
            r_out_kind <= KIND_WINDOW;
            r_out_xf   <= r_job.x_first;
            r_out_xl   <= r_job.x_last;
            r_out_yf   <= r_job.y_first;
            r_out_yl   <= r_job.y_last;
            r_out_pa   <= '0;
            r_out_pb   <= '0;
            r_out_last <= (r_job.count == '0);
        end else if (mv) begin
            r_out_kind <= KIND_PIXELS;
            r_out_xf   <= '0;
            r_out_xl   <= '0;
            r_out_yf   <= '0;
            r_out_yl   <= '0;
            r_out_pa   <= expand4(r_rd_data[7:4], i_cfg.text_color, i_cfg.back_color);
            r_out_pb   <= expand4(r_rd_data[3:0], i_cfg.text_color, i_cfg.back_color);
            r_out_last <= (CNT_W'(r_sent + 1'b1) == r_job.count);
        end
    end

    assign o_res.valid    = r_out_valid;
    assign o_res.kind     = r_out_kind;
    assign o_res.x_first  = r_out_xf;
    assign o_res.x_last   = r_out_xl;
    assign o_res.y_first  = r_out_yf;
    assign o_res.y_last   = r_out_yl;
    assign o_res.pixels_a = r_out_pa;
    assign o_res.pixels_b = r_out_pb;
    assign o_res.last     = r_out_last;

    // A fetched byte only ever waits while a draw is streaming.
    a_rd_in_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_valid |-> (r_state == B_BYTES))
        else $error("glyph byte pending outside the byte phase");

    // Bytes issued to the memory are either sent or pending in the read register.
    a_issue_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_BYTES) |-> (CNT_W'(r_issue - r_sent) == CNT_W'(r_rd_valid)))
        else $error("glyph read count out of step with sent items");

    // The byte phase never runs past the glyph byte count.
    a_sent_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_BYTES) |-> (r_sent < r_job.count))
        else $error("more color items than glyph bytes");

endmodule

`default_nettype wire

[tb/sv/tb_bitmap_text_glyph_renderer.sv]
// Self-checking testbench of the bitmap text glyph renderer: font loads and
// character draws go in, window and color items come out and are compared.
// Depends on btgr_pkg, btgr_ifs and the RTL top bitmap_text_glyph_renderer.

module tb_bitmap_text_glyph_renderer;
    import btgr_pkg::*;

    // Cycles to wait after the last expected item before a register write, so
    // that loads still in the queue are done with. Loads give no item.
    localparam int SETTLE_CYCLES   = 16;
    localparam int TAIL_CYCLES     = 64;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int RAND_PHASES     = 6;
    localparam int ITEMS_PER_PHASE = 21;
    localparam int MAX_REPORTS     = 40;
    // Font bytes loaded before the first draw: the bottom of the memory holds
    // the glyphs from space upward, the top holds the glyph of the code just
    // below space, which wraps to the end of the memory.
    localparam int PRELOAD_LOW     = 64;
    localparam int PRELOAD_HIGH    = 48;
    localparam int CODE_TRIES      = 8;

    typedef enum logic {ROW_ITEM, ROW_REG} t_row_kind;

    typedef struct packed {
        logic [15:0] x_first;
        logic [15:0] x_last;
        logic [15:0] y_first;
        logic [15:0] y_last;
    } t_win;

    // One command item as the sender offers it. When pinned is set, the
    // window item of this draw is taken from win instead of the predictor.
    typedef struct packed {
        logic               cmd;
        logic [FONT_AW-1:0] font_addr;
        logic [7:0]         font_byte;
        logic [7:0]         char_code;
        logic               new_string;
        logic [15:0]        start_line;
        logic               pinned;
        t_win               win;
    } t_glyph_cmd;

    typedef struct packed {
        t_row_kind   kind;
        logic [2:0]  reg_idx;
        logic [31:0] reg_val;
        t_glyph_cmd  item;
    } t_script_row;

    typedef struct packed {
        logic        kind;
        logic [15:0] x_first;
        logic [15:0] x_last;
        logic [15:0] y_first;
        logic [15:0] y_last;
        logic [63:0] pixels_a;
        logic [63:0] pixels_b;
        logic        last;
    } t_glyph_res;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    btgr_item_if item_if ();
    btgr_res_if  res_if ();

    bitmap_text_glyph_renderer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow of the block: font image, text pen and register file. The
    // written flags keep draws on glyphs whose bytes have all been loaded.
    logic [7:0]  font_image [FONT_BYTES];
    bit          font_written [FONT_BYTES];
    logic [15:0] pen_x;
    logic [15:0] pen_line;
    t_cfg        cfg_shadow;

    t_glyph_res  glyph_results_due [$];
    t_script_row script [$];

    int mismatch_count;
    int results_seen;
    int burst_left;
    bit hold_off_req;

    // Clock and reset.
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Watchdog: a correct run ends long before this count is reached.
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        if (mismatch_count < MAX_REPORTS) begin
            $display("ERROR result %0d, %s: got 0x%0h, expected 0x%0h",
                     results_seen, what, got, want);
        end
        mismatch_count++;
    endtask

    // Four colors of one glyph byte half: the MSB is the leftmost pixel and
    // lands in the top 16 bits.
    function automatic logic [63:0] four_colors(input logic [3:0] bits);
        logic [63:0] word;
        int k;
        word = '0;
        for (k = 0; k < 4; k++) begin
            word[63-16*k -: 16] = bits[3-k] ? cfg_shadow.text_color
                                            : cfg_shadow.back_color;
        end
        return word;
    endfunction

    // True when every byte that a draw of this code reads under the current
    // glyph size has been loaded.
    function automatic bit glyph_loaded(input logic [7:0] code);
        int          nb;
        int          b;
        int          i;
        logic [15:0] off;
        bit          ok;
        nb = (int'(cfg_shadow.glyph_width) * int'(cfg_shadow.glyph_height)) / 8;
        if (nb > MAX_GLYPH_BYTES) nb = MAX_GLYPH_BYTES;
        off = {8'd0, code} - {8'd0, FIRST_CODE};
        b   = (int'(off) * nb) % FONT_BYTES;
        ok  = 1'b1;
        for (i = 0; i < nb; i++) begin
            if (!font_written[(b + i) % FONT_BYTES]) ok = 1'b0;
        end
        return ok;
    endfunction

    // Predicts the items one accepted command causes. A load only updates
    // the font image. A draw first applies the new string, then the
    // horizontal wrap, then the bottom overflow back to the window origin,
    // all in 16-bit modular arithmetic, and advances the pen afterwards.
    task automatic render_glyph(input t_glyph_cmd c);
        logic [15:0] gw;
        logic [15:0] gh;
        logic [15:0] span;
        logic [15:0] offset;
        int          nbytes;
        int          base;
        int          i;
        logic [7:0]  bits;
        t_glyph_res  r;

        if (c.cmd == CMD_LOAD) begin
            font_image[c.font_addr]   = c.font_byte;
            font_written[c.font_addr] = 1'b1;
            return;
        end
        gw = {11'd0, cfg_shadow.glyph_width};
        gh = {11'd0, cfg_shadow.glyph_height};
        if (c.new_string) begin
            pen_line = c.start_line;
            pen_x    = 16'd0;
        end
        span = pen_x - cfg_shadow.win_x + gw;
        if (span > cfg_shadow.screen_w) begin
            pen_x    = cfg_shadow.win_x;
            pen_line = pen_line + gh;
        end
        span = pen_line - cfg_shadow.win_y + gh;
        if (span > cfg_shadow.screen_h) begin
            pen_x    = cfg_shadow.win_x;
            pen_line = cfg_shadow.win_y;
        end

        // Byte count is floored and saturated; codes below space wrap.
        nbytes = (int'(gw) * int'(gh)) / 8;
        if (nbytes > MAX_GLYPH_BYTES) nbytes = MAX_GLYPH_BYTES;
        offset = {8'd0, c.char_code} - {8'd0, FIRST_CODE};
        base   = (int'(offset) * nbytes) % FONT_BYTES;

        r         = '0;
        r.kind    = KIND_WINDOW;
        r.x_first = pen_x;
        r.x_last  = pen_x + gw - 16'd1;
        r.y_first = pen_line;
        r.y_last  = pen_line + gh - 16'd1;
        r.last    = (nbytes == 0);
        if (c.pinned) begin
            r.x_first = c.win.x_first;
            r.x_last  = c.win.x_last;
            r.y_first = c.win.y_first;
            r.y_last  = c.win.y_last;
        end
        glyph_results_due.push_back(r);

        for (i = 0; i < nbytes; i++) begin
            bits       = font_image[(base + i) % FONT_BYTES];
            r          = '0;
            r.kind     = KIND_PIXELS;
            r.pixels_a = four_colors(bits[7:4]);
            r.pixels_b = four_colors(bits[3:0]);
            r.last     = (i == nbytes - 1);
            glyph_results_due.push_back(r);
        end
        pen_x = pen_x + gw;
    endtask

    // Offers one command item and returns in the time step in which it was
    // accepted. The sender works in bursts; a gap drops valid for a while.
    task automatic offer_item(input t_glyph_cmd c);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 8);
        end
        burst_left--;
        if (gap > 0) begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_if.valid      <= 1'b1;
        item_if.cmd        <= c.cmd;
        item_if.font_addr  <= c.font_addr;
        item_if.font_byte  <= c.font_byte;
        item_if.char_code  <= c.char_code;
        item_if.new_string <= c.new_string;
        item_if.start_line <= c.start_line;
        @(posedge i_clk);
        while (!item_if.ready) @(posedge i_clk);
        render_glyph(c);
    endtask

    // Stops offering and waits until every expected item has come out and
    // any trailing loads have drained, so registers can be written.
    task automatic wait_idle();
        item_if.valid <= 1'b0;
        while (glyph_results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Setup cycle, then the access cycle; the register takes the value at the
    // edge that ends the access. The bus is left idle after each write.
    task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_GLYPH_WIDTH:  cfg_shadow.glyph_width  = val[4:0];
            REG_GLYPH_HEIGHT: cfg_shadow.glyph_height = val[4:0];
            REG_TEXT_COLOR:   cfg_shadow.text_color   = val[15:0];
            REG_BACK_COLOR:   cfg_shadow.back_color   = val[15:0];
            REG_SCREEN_W:     cfg_shadow.screen_w     = val[15:0];
            REG_SCREEN_H:     cfg_shadow.screen_h     = val[15:0];
            REG_WIN_X:        cfg_shadow.win_x        = val[15:0];
            REG_WIN_Y:        cfg_shadow.win_y        = val[15:0];
            default: ;
        endcase
    endtask

    function automatic t_script_row row_load(input logic [FONT_AW-1:0] a,
                                             input logic [7:0] b);
        t_script_row r;
        r                = '0;
        r.kind           = ROW_ITEM;
        r.item.cmd       = CMD_LOAD;
        r.item.font_addr = a;
        r.item.font_byte = b;
        return r;
    endfunction

    function automatic t_script_row row_draw(input logic [7:0] code, input logic ns,
                                             input logic [15:0] line);
        t_script_row r;
        r                 = '0;
        r.kind            = ROW_ITEM;
        r.item.cmd        = CMD_DRAW;
        r.item.char_code  = code;
        r.item.new_string = ns;
        r.item.start_line = line;
        return r;
    endfunction

    // A draw whose window is known in advance and typed in by hand.
    function automatic t_script_row row_placed(input logic [7:0] code, input logic ns,
                                               input logic [15:0] line,
                                               input logic [15:0] xf, input logic [15:0] xl,
                                               input logic [15:0] yf, input logic [15:0] yl);
        t_script_row r;
        r             = row_draw(code, ns, line);
        r.item.pinned = 1'b1;
        r.item.win    = '{x_first: xf, x_last: xl, y_first: yf, y_last: yl};
        return r;
    endfunction

    function automatic t_script_row row_reg(input logic [2:0] idx,
                                            input logic [31:0] val);
        t_script_row r;
        r         = '0;
        r.kind    = ROW_REG;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    // Result monitor: every accepted item is checked against the oldest
    // expectation, field by field.
    always @(posedge i_clk) begin
        t_glyph_res got;
        t_glyph_res want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = '{kind: res_if.kind, x_first: res_if.x_first, x_last: res_if.x_last,
                    y_first: res_if.y_first, y_last: res_if.y_last,
                    pixels_a: res_if.pixels_a, pixels_b: res_if.pixels_b,
                    last: res_if.last};
            if (glyph_results_due.size() == 0) begin
                flag_mismatch("unexpected item", {63'd0, got.kind}, 64'd0);
            end else begin
                want = glyph_results_due.pop_front();
                if (got.kind !== want.kind)
                    flag_mismatch("kind", 64'(got.kind), 64'(want.kind));
                if (got.x_first !== want.x_first)
                    flag_mismatch("x_first", 64'(got.x_first), 64'(want.x_first));
                if (got.x_last !== want.x_last)
                    flag_mismatch("x_last", 64'(got.x_last), 64'(want.x_last));
                if (got.y_first !== want.y_first)
                    flag_mismatch("y_first", 64'(got.y_first), 64'(want.y_first));
                if (got.y_last !== want.y_last)
                    flag_mismatch("y_last", 64'(got.y_last), 64'(want.y_last));
                if (got.pixels_a !== want.pixels_a)
                    flag_mismatch("pixels_a", got.pixels_a, want.pixels_a);
                if (got.pixels_b !== want.pixels_b)
                    flag_mismatch("pixels_b", got.pixels_b, want.pixels_b);
                if (got.last !== want.last)
                    flag_mismatch("last", 64'(got.last), 64'(want.last));
            end
            results_seen++;
        end
    end

    // Result receiver. It changes its stall pattern every segment: always
    // ready, coin flips, a repeating bit mask, or mostly stalled. As soon as
    // it is asked, it holds off for a long stretch so the queue fills and the
    // input stalls.
    initial begin : result_sink
        int       seg;
        int       mode;
        int       k;
        int       n;
        logic [7:0] pat;
        bit       held;
        held         = 1'b0;
        res_if.ready = 1'b0;
        forever begin
            seg  = $urandom_range(8, 120);
            mode = $urandom_range(0, 3);
            pat  = 8'($urandom_range(1, 255));
            for (k = 0; k < seg; k++) begin
                if (hold_off_req && !held) begin
                    held = 1'b1;
                    res_if.ready <= 1'b0;
                    for (n = 0; n < HOLD_OFF_CYCLES; n++) @(posedge i_clk);
                end
                case (mode)
                    0:       res_if.ready <= 1'b1;
                    1:       res_if.ready <= 1'($urandom_range(0, 1));
                    2:       res_if.ready <= pat[k % 8];
                    default: res_if.ready <= ($urandom_range(0, 7) == 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    // Stimulus and verdict.
    initial begin : stimulus
        t_glyph_cmd it;
        t_cfg       nc;
        int         a;
        int         ph;
        int         n;
        int         tries;

        mismatch_count = 0;
        results_seen   = 0;
        burst_left     = 0;
        hold_off_req   = 1'b0;

        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        item_if.valid      = 1'b0;
        item_if.cmd        = CMD_LOAD;
        item_if.font_addr  = '0;
        item_if.font_byte  = '0;
        item_if.char_code  = '0;
        item_if.new_string = 1'b0;
        item_if.start_line = '0;

        // Register defaults and cursor after reset.
        pen_x                   = 16'd0;
        pen_line                = 16'd0;
        cfg_shadow.glyph_width  = 5'd8;
        cfg_shadow.glyph_height = 5'd16;
        cfg_shadow.text_color   = 16'h0000;
        cfg_shadow.back_color   = 16'h0000;
        cfg_shadow.screen_w     = 16'd240;
        cfg_shadow.screen_h     = 16'd320;
        cfg_shadow.win_x        = 16'd0;
        cfg_shadow.win_y        = 16'd0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The glyph memory is not cleared by reset, so the bottom and the top
        // of the memory are loaded with random content first. Every draw
        // below reads only glyphs whose bytes have all been loaded.
        for (a = 0; a < PRELOAD_LOW + PRELOAD_HIGH; a++) begin
            it           = '0;
            it.cmd       = CMD_LOAD;
            it.font_addr = FONT_AW'((a < PRELOAD_LOW) ? a
                                    : FONT_BYTES - PRELOAD_LOW - PRELOAD_HIGH + a);
            it.font_byte = 8'($urandom_range(0, 255));
            offer_item(it);
        end

        // Directed part. At the reset settings (8x16 glyphs, 240x320 screen)
        // the windows are easy to state: plain advance, a string at the last
        // row that fits, one row lower that overflows back to the origin, and
        // a start line at the top of the 16-bit range whose last row wraps.
        script.push_back(row_placed(8'd32, 1'b0, 16'd0, 16'd0, 16'd7, 16'd0, 16'd15));
        script.push_back(row_placed(8'd33, 1'b0, 16'd0, 16'd8, 16'd15, 16'd0, 16'd15));
        script.push_back(row_placed(8'd34, 1'b1, 16'd304, 16'd0, 16'd7, 16'd304, 16'd319));
        script.push_back(row_placed(8'd35, 1'b1, 16'd305, 16'd0, 16'd7, 16'd0, 16'd15));
        script.push_back(row_placed(8'd31, 1'b1, 16'hFFFF, 16'd0, 16'd7, 16'hFFFF, 16'd14));
        script.push_back(row_load(13'h1FFF, 8'hFF));
        script.push_back(row_load(13'h0000, 8'h00));
        script.push_back(row_load(13'h0AAA, 8'h5A));

        // Largest glyph (48 bytes) on a 40x60 screen: two glyphs per line,
        // two lines, then a wrap that also overflows the bottom.
        script.push_back(row_reg(REG_TEXT_COLOR, 32'h0000_FFFF));
        script.push_back(row_reg(REG_BACK_COLOR, 32'h0000_0000));
        script.push_back(row_reg(REG_GLYPH_WIDTH, 32'd16));
        script.push_back(row_reg(REG_GLYPH_HEIGHT, 32'd24));
        script.push_back(row_reg(REG_SCREEN_W, 32'd40));
        script.push_back(row_reg(REG_SCREEN_H, 32'd60));
        script.push_back(row_placed(8'd32, 1'b1, 16'd0, 16'd0, 16'd15, 16'd0, 16'd23));
        script.push_back(row_placed(8'd31, 1'b0, 16'd0, 16'd16, 16'd31, 16'd0, 16'd23));
        script.push_back(row_placed(8'd32, 1'b0, 16'd0, 16'd0, 16'd15, 16'd24, 16'd47));
        script.push_back(row_placed(8'd31, 1'b0, 16'd0, 16'd16, 16'd31, 16'd24, 16'd47));
        script.push_back(row_placed(8'd32, 1'b0, 16'd0, 16'd0, 16'd15, 16'd0, 16'd23));

        // A 1x1 glyph has no bytes at all: the window item alone, marked last.
        // Maximum screen and origins exercise the modular wrap checks.
        script.push_back(row_reg(REG_GLYPH_WIDTH, 32'd1));
        script.push_back(row_reg(REG_GLYPH_HEIGHT, 32'd1));
        script.push_back(row_reg(REG_TEXT_COLOR, 32'h0000_1234));
        script.push_back(row_reg(REG_BACK_COLOR, 32'h0000_FFFF));
        script.push_back(row_reg(REG_SCREEN_W, 32'h0000_FFFF));
        script.push_back(row_reg(REG_SCREEN_H, 32'h0000_FFFF));
        script.push_back(row_reg(REG_WIN_X, 32'h0000_FFFF));
        script.push_back(row_reg(REG_WIN_Y, 32'h0000_FFFF));
        script.push_back(row_placed(8'd90, 1'b1, 16'd100, 16'd0, 16'd0, 16'd100, 16'd100));
        script.push_back(row_placed(8'd91, 1'b0, 16'd0, 16'd1, 16'd1, 16'd100, 16'd100));

        // A 3x5 glyph has an area that is not a multiple of eight, so its
        // count floors to one byte. A 1x1 screen forces both wraps every draw.
        script.push_back(row_reg(REG_GLYPH_WIDTH, 32'd3));
        script.push_back(row_reg(REG_GLYPH_HEIGHT, 32'd5));
        script.push_back(row_reg(REG_SCREEN_W, 32'd1));
        script.push_back(row_reg(REG_SCREEN_H, 32'd1));
        script.push_back(row_reg(REG_WIN_X, 32'd0));
        script.push_back(row_reg(REG_WIN_Y, 32'd0));
        script.push_back(row_placed(8'd40, 1'b1, 16'd0, 16'd0, 16'd2, 16'd0, 16'd4));
        script.push_back(row_placed(8'd0, 1'b0, 16'd0, 16'd0, 16'd2, 16'd0, 16'd4));

        // 16x3 glyphs with a nonzero origin, a code just below space, and a
        // load in the middle of a string; these are left to the predictor.
        script.push_back(row_reg(REG_GLYPH_WIDTH, 32'd16));
        script.push_back(row_reg(REG_GLYPH_HEIGHT, 32'd3));
        script.push_back(row_reg(REG_TEXT_COLOR, 32'h0000_0000));
        script.push_back(row_reg(REG_SCREEN_W, 32'd240));
        script.push_back(row_reg(REG_SCREEN_H, 32'd320));
        script.push_back(row_reg(REG_WIN_X, 32'd10));
        script.push_back(row_reg(REG_WIN_Y, 32'd20));
        script.push_back(row_draw(8'd33, 1'b1, 16'd200));
        script.push_back(row_draw(8'd41, 1'b0, 16'd0));
        script.push_back(row_draw(8'd31, 1'b0, 16'd0));
        script.push_back(row_load(13'd100, 8'hC3));
        script.push_back(row_draw(8'd34, 1'b0, 16'd0));

        foreach (script[i]) begin
            if (script[i].kind == ROW_REG) begin
                wait_idle();
                apb_write(script[i].reg_idx, script[i].reg_val);
            end else begin
                offer_item(script[i].item);
            end
        end

        // Random part: a fresh register setting per phase, the first two at
        // the largest and the smallest glyph. Screens are, half the time, one to
        // six glyphs wide and one to five high so that both wraps happen often.
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            wait_idle();
            case (ph)
                0: begin
                    nc.glyph_width  = 5'd16;
                    nc.glyph_height = 5'd24;
                end
                1: begin
                    nc.glyph_width  = 5'd1;
                    nc.glyph_height = 5'd1;
                end
                default: begin
                    nc.glyph_width  = 5'($urandom_range(1, 16));
                    nc.glyph_height = 5'($urandom_range(1, 24));
                end
            endcase
            nc.text_color = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                        : 16'($urandom_range(0, 65535));
            nc.back_color = ($urandom_range(0, 3) == 0) ? 16'h0000
                                                        : 16'($urandom_range(0, 65535));
            case ($urandom_range(0, 5))
                0:       nc.screen_w = 16'd1;
                1:       nc.screen_w = 16'hFFFF;
                2:       nc.screen_w = 16'($urandom_range(0, 65535));
                default: nc.screen_w = 16'($urandom_range(nc.glyph_width,
                                                          6 * nc.glyph_width));
            endcase
            case ($urandom_range(0, 5))
                0:       nc.screen_h = 16'd1;
                1:       nc.screen_h = 16'hFFFF;
                2:       nc.screen_h = 16'($urandom_range(0, 65535));
                default: nc.screen_h = 16'($urandom_range(nc.glyph_height,
                                                          5 * nc.glyph_height));
            endcase
            case ($urandom_range(0, 5))
                0:       nc.win_x = 16'hFFFF;
                1:       nc.win_x = 16'($urandom_range(0, 65535));
                2:       nc.win_x = 16'($urandom_range(0, 64));
                default: nc.win_x = 16'd0;
            endcase
            case ($urandom_range(0, 5))
                0:       nc.win_y = 16'hFFFF;
                1:       nc.win_y = 16'($urandom_range(0, 65535));
                2:       nc.win_y = 16'($urandom_range(0, 64));
                default: nc.win_y = 16'd0;
            endcase
            apb_write(REG_GLYPH_WIDTH, {27'd0, nc.glyph_width});
            apb_write(REG_GLYPH_HEIGHT, {27'd0, nc.glyph_height});
            apb_write(REG_TEXT_COLOR, {16'd0, nc.text_color});
            apb_write(REG_BACK_COLOR, {16'd0, nc.back_color});
            apb_write(REG_SCREEN_W, {16'd0, nc.screen_w});
            apb_write(REG_SCREEN_H, {16'd0, nc.screen_h});
            apb_write(REG_WIN_X, {16'd0, nc.win_x});
            apb_write(REG_WIN_Y, {16'd0, nc.win_y});

            // Midway the receiver stalls for a long time while items keep
            // coming, which backs the queue up into the input channel.
            if (ph == 2) hold_off_req = 1'b1;

            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                it            = '0;
                it.font_addr  = FONT_AW'($urandom_range(0, FONT_BYTES - 1));
                it.font_byte  = 8'($urandom_range(0, 255));
                it.char_code  = 8'($urandom_range(0, 255));
                it.new_string = ($urandom_range(0, 6) == 0);
                it.start_line = 16'($urandom_range(0, 65535));
                if ($urandom_range(0, 4) == 0) begin
                    it.cmd = CMD_LOAD;
                end else begin
                    it.cmd = CMD_DRAW;
                    if ($urandom_range(0, 1) == 0)
                        it.start_line = 16'($urandom_range(0, cfg_shadow.screen_h));
                    // Pick a code whose glyph is fully loaded; the glyphs of
                    // space and of the code just below it always are.
                    tries = 0;
                    while (!glyph_loaded(it.char_code) && tries < CODE_TRIES) begin
                        it.char_code = 8'($urandom_range(24, 40));
                        tries++;
                    end
                    if (!glyph_loaded(it.char_code))
                        it.char_code = ($urandom_range(0, 1) == 0) ? 8'd31 : 8'd32;
                end
                offer_item(it);
            end
        end

        // Drain, then give the block time to show any stray item.
        item_if.valid <= 1'b0;
        while (glyph_results_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
